[src/lag_pkg.sv]
package lag_pkg;

    localparam int SIDE      = 64;
    localparam int CELLS     = SIDE * SIDE;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int COORD_W   = 6;
    localparam int COUNT_W   = 13;
    localparam int NB_W      = 4;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Conway's rule: survive on two or three neighbours, birth on three.
    localparam logic [NB_W-1:0] NB_TWO   = 4'd2;
    localparam logic [NB_W-1:0] NB_THREE = 4'd3;

    typedef struct packed {
        logic                 shift;
        logic                 load;
        logic [IDX_W-1:0]     addr;
        logic                 wr_en;
        logic                 wr_val;
    } t_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_STEP = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

[src/lag_cell.sv]
module lag_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_load,
    input  logic i_load_val,
    input  logic i_prev,
    output logic o_q
);

    logic r_q;

    // Holds one cell; in shift mode the grid rotates one place per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= 1'b0;
        end else if (i_load) begin
            r_q <= i_load_val;
        end else if (i_shift) begin
            r_q <= i_prev;
        end
    end

    assign o_q = r_q;

endmodule

[src/lag_ring.sv]
module lag_ring (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lag_pkg::t_ctrl      i_ctrl,
    input  logic                i_new_val,
    output logic [lag_pkg::CELLS-1:0] o_cells
);

    logic [lag_pkg::CELLS-1:0] w_load;
    logic [lag_pkg::CELLS-1:0] w_lval;

    // The cell at index CELLS-1 takes the newly computed value while the ring
    // shifts, so after CELLS shifts the whole grid holds the next generation.
    for (genvar g = 0; g < lag_pkg::CELLS; g++) begin : g_cell
        always_comb begin
            w_load[g] = i_ctrl.wr_en && (i_ctrl.addr == lag_pkg::IDX_W'(g));
            w_lval[g] = i_ctrl.wr_val;
        end
        if (g == lag_pkg::CELLS - 1) begin : g_tail
            lag_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (i_ctrl.shift),
                .i_load     (w_load[g]),
                .i_load_val (w_lval[g]),
                .i_prev     (i_new_val),
                .o_q        (o_cells[g])
            );
        end else begin : g_body
            lag_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (i_ctrl.shift),
                .i_load     (w_load[g]),
                .i_load_val (w_lval[g]),
                .i_prev     (o_cells[g+1]),
                .o_q        (o_cells[g])
            );
        end
    end

endmodule

[src/life_automaton_generation_unit.sv]
// Toroidal Game of Life engine on a 64 by 64 grid of one-bit cells, cleared
// at reset. Each request returns exactly one response. The grid lives in two
// rings of cells: one holds the current generation and the other receives
// the next. A request is taken while idle; a write then goes to the done
// state, a read to a read state and then the done state, and a step to a
// step state that takes each cell of the grid in turn and then the done
// state, which loads the response when w_free is high. During a step both
// rings rotate by one cell per cycle. The current ring feeds its head back
// to its tail, so the eight neighbours of the cell at its head always sit at
// fixed taps, with the wrap-around at the left and right edges chosen by the
// column of that cell; the next ring takes the new value of that cell at its
// tail. After a full turn the current ring is back in place, the next ring
// holds the new generation, and the two swap roles. Requests are taken only
// while the block is idle, so a step holds off further requests for its
// whole length. The response register is separate, so a new request may be
// accepted while a response still waits to be taken; the response to that
// request is then held back until the waiting one has gone.
module life_automaton_generation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic        i_write_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_read_value,
    output logic [12:0] o_live_count
);

    localparam int S  = lag_pkg::SIDE;
    localparam int N  = lag_pkg::CELLS;
    localparam int IW = lag_pkg::IDX_W;
    localparam int CW = lag_pkg::COORD_W;

    lag_pkg::t_state r_state, n_state;
    lag_pkg::t_ctrl  w_ctrl;
    lag_pkg::t_ctrl  w_ctrl_a, w_ctrl_b;

    logic [N-1:0]                  w_cells_a, w_cells_b, w_cells;
    logic                          w_tail_a, w_tail_b;
    logic                          r_bank, n_bank;
    logic [IW:0]                   r_cnt, n_cnt;
    logic [lag_pkg::COUNT_W-1:0]   r_live, n_live;
    logic [IW-1:0]                 r_addr, n_addr;
    logic                          r_rd, n_rd;
    logic                          r_ovalid, n_ovalid;
    logic                          r_orv, n_orv;
    logic [lag_pkg::COUNT_W-1:0]   r_olc, n_olc;
    logic                          w_acc;
    logic                          w_free;
    logic [CW-1:0]                 w_col;
    logic                          w_first_col, w_last_col;
    logic [7:0]                    w_nbr;
    logic [lag_pkg::NB_W-1:0]      w_nb;
    logic                          w_new;

    // The output register can take a new response when empty or being taken.
    assign w_free  = !r_ovalid || !i_stall;
    assign o_stall = (r_state != lag_pkg::ST_IDLE);
    assign w_acc   = i_valid && !o_stall;

    // Bank select: r_bank low means ring A holds the current generation.
    assign w_cells  = r_bank ? w_cells_b : w_cells_a;
    assign w_tail_a = r_bank ? w_new : w_cells_a[0];
    assign w_tail_b = r_bank ? w_cells_b[0] : w_new;

    // Writes go to the current ring only; both rings rotate during a step.
    always_comb begin
        w_ctrl_a       = w_ctrl;
        w_ctrl_b       = w_ctrl;
        w_ctrl_a.wr_en = w_ctrl.wr_en && !r_bank;
        w_ctrl_b.wr_en = w_ctrl.wr_en && r_bank;
    end

    lag_ring u_ring_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl_a),
        .i_new_val (w_tail_a),
        .o_cells   (w_cells_a)
    );

    lag_ring u_ring_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl_b),
        .i_new_val (w_tail_b),
        .o_cells   (w_cells_b)
    );

    // After k rotations ring index i holds cell (k+i) mod N, so the cell
    // under evaluation is at index 0 and a cell d places behind it sits at
    // index N-d. Row wrap-around falls out of the modulo; column wrap-around
    // moves the left taps one row down in the first column and the right
    // taps one row up in the last column.
    assign w_col       = r_cnt[CW-1:0];
    assign w_first_col = (w_col == '0);
    assign w_last_col  = (w_col == CW'(S-1));

    assign w_nbr[0] = w_first_col ? w_cells[N-1]     : w_cells[N-S-1];
    assign w_nbr[1] = w_cells[N-S];
    assign w_nbr[2] = w_last_col  ? w_cells[N-2*S+1] : w_cells[N-S+1];
    assign w_nbr[3] = w_first_col ? w_cells[S-1]     : w_cells[N-1];
    assign w_nbr[4] = w_last_col  ? w_cells[N-S+1]   : w_cells[1];
    assign w_nbr[5] = w_first_col ? w_cells[2*S-1]   : w_cells[S-1];
    assign w_nbr[6] = w_cells[S];
    assign w_nbr[7] = w_last_col  ? w_cells[1]       : w_cells[S+1];

    always_comb begin
        w_nb = '0;
        for (int i = 0; i < 8; i++) begin
            w_nb = w_nb + lag_pkg::NB_W'(w_nbr[i]);
        end
        w_new = w_cells[0] ? (w_nb == lag_pkg::NB_TWO || w_nb == lag_pkg::NB_THREE)
                           : (w_nb == lag_pkg::NB_THREE);
    end

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_cnt    = r_cnt;
        n_live   = r_live;
        n_addr   = r_addr;
        n_rd     = r_rd;
        n_ovalid = r_ovalid && i_stall;
        n_orv    = r_orv;
        n_olc    = r_olc;
        w_ctrl   = '0;
        w_ctrl.addr   = r_addr;
        w_ctrl.wr_val = i_write_value;
        case (r_state)
            lag_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_addr = {i_row, i_col};
                    case (i_op)
                        lag_pkg::OP_WRITE: begin
                            w_ctrl.addr  = {i_row, i_col};
                            w_ctrl.wr_en = 1'b1;
                            n_rd  = 1'b0;
                            n_state = lag_pkg::ST_DONE;
                        end
                        lag_pkg::OP_READ: begin
                            n_state = lag_pkg::ST_READ;
                        end
                        lag_pkg::OP_STEP: begin
                            n_cnt   = '0;
                            n_live  = '0;
                            n_state = lag_pkg::ST_STEP;
                        end
                        default: begin
                            n_rd    = 1'b0;
                            n_state = lag_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lag_pkg::ST_READ: begin
                n_rd    = w_cells[r_addr];
                n_state = lag_pkg::ST_DONE;
            end
            lag_pkg::ST_STEP: begin
                w_ctrl.shift = 1'b1;
                if (w_new && r_live != '1) begin
                    n_live = r_live + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (IW+1)'(N-1)) begin
                    n_rd    = 1'b0;
                    n_bank  = !r_bank;
                    n_state = lag_pkg::ST_DONE;
                end
            end
            lag_pkg::ST_DONE: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_orv    = r_rd;
                    n_olc    = (r_cnt == (IW+1)'(N)) ? r_live : '0;
                    n_cnt    = '0;
                    n_state  = lag_pkg::ST_IDLE;
                end
            end
            default: n_state = lag_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lag_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_bank   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_bank   <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_live <= n_live;
        r_addr <= n_addr;
        r_rd   <= n_rd;
        r_orv  <= n_orv;
        r_olc  <= n_olc;
    end

    assign o_valid      = r_ovalid;
    assign o_read_value = r_orv;
    assign o_live_count = r_olc;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lag_pkg::ST_STEP) |-> o_stall)
        else $error("request taken during a step");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lag_pkg::ST_STEP) |-> (r_cnt < (IW+1)'(N)))
        else $error("step counter overran the grid");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_live_count)))
        else $error("stalled response changed");

endmodule
